// ===== rtl/hrht_pkg.sv =====
package hrht_pkg;

  // Item kind codes on the input channel
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EOS   = 2'd1,
    KIND_START = 2'd2
  } kind_e;

  // Parser states; codes above ST_DONE are never entered and act as finished
  typedef enum logic [3:0] {
    ST_RL_START   = 4'd0,
    ST_RL_METHOD  = 4'd1,
    ST_RL_URL     = 4'd2,
    ST_RL_VERSION = 4'd3,
    ST_RL_END     = 4'd4,
    ST_RL_ERROR   = 4'd5,
    ST_HD_START   = 4'd6,
    ST_HD_KEY     = 4'd7,
    ST_HD_VALUE   = 4'd8,
    ST_HD_NEXT    = 4'd9,
    ST_HD_LINEEND = 4'd10,
    ST_HD_END     = 4'd11,
    ST_HD_ERROR   = 4'd12,
    ST_DONE       = 4'd13
  } parse_state_e;

  typedef enum logic [2:0] {
    TK_SKIP    = 3'd0,
    TK_METHOD  = 3'd1,
    TK_URL     = 3'd2,
    TK_VERSION = 3'd3,
    TK_KEY     = 3'd4,
    TK_VALUE   = 3'd5,
    TK_LINEEND = 3'd6,
    TK_HEADEND = 3'd7
  } token_e;

  typedef enum logic [1:0] {
    SS_BUSY      = 2'd0,
    SS_COMPLETE  = 2'd1,
    SS_BAD       = 2'd2,
    SS_TRUNCATED = 2'd3
  } status_e;

  // Character constants
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_CASE_BIT = 8'h20;

  // Parser state carried from beat to beat
  typedef struct packed {
    parse_state_e parse_state;
    logic         value_started;
    status_e      final_status;
  } hrht_state_t;

  // One result beat
  typedef struct packed {
    logic [7:0] char_out;
    token_e     token_class;
    status_e    status;
  } hrht_result_t;

endpackage

// ===== rtl/hrht_if.sv =====
// Input channel: one request byte or control beat
interface hrht_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_in;

  modport source (output valid, output kind, output byte_in, input ready);
  modport sink   (input valid, input kind, input byte_in, output ready);
endinterface

// Output channel: one tagged byte with status
interface hrht_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [2:0] token_class;
  logic [1:0] status;

  modport source (output valid, output char_out, output token_class, output status,
                  input ready);
  modport sink   (input valid, input char_out, input token_class, input status,
                  output ready);
endinterface

// ===== rtl/http_request_head_tokenizer_unit.sv =====
// Channel | Dir | Beat payload                      | Accepted when
// in_i    | in  | kind[1:0], byte_in[7:0]           | valid && ready
// out_o   | out | char_out[7:0], token_class[2:0],  | valid && ready
//         |     | status[1:0]                       |
//
// Each beat is registered on entry, classified combinationally from the input
// register against the parser state, and lands in the output register.
// One beat per cycle is sustained while out_o.ready holds; the state register update sets that rate.
// A stalled output holds the output register and, once the input register is
// also full, drops in_i.ready. Reset (rst_ni low, asynchronous) returns the
// parser to the start of a request line with status in progress.
module http_request_head_tokenizer_unit import hrht_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  hrht_in_if.sink    in_i,
  hrht_out_if.source out_o
);

  logic         s1_valid_q;
  logic [1:0]   s1_kind_q;
  logic [7:0]   s1_byte_q;
  logic         s1_advance;
  logic         out_valid_q;
  hrht_result_t out_q;
  hrht_result_t result_d;
  hrht_state_t  state_q;
  hrht_state_t  state_d;

  // Handshake: stage 1 moves when the output register is free or draining
  assign s1_advance = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_kind_q <= in_i.kind;
      s1_byte_q <= in_i.byte_in;
    end
  end

  hrht_classify u_classify (
    .state_i  (state_q),
    .kind_i   (s1_kind_q),
    .byte_i   (s1_byte_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.parse_state   <= ST_RL_START;
      state_q.value_started <= 1'b0;
      state_q.final_status  <= SS_BUSY;
    end else if (s1_advance) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_q <= result_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.char_out    = out_q.char_out;
  assign out_o.token_class = out_q.token_class;
  assign out_o.status      = out_q.status;

`ifndef NO_ASSERTIONS
  // Finished state and a final status always go together
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.parse_state == ST_DONE) == (state_q.final_status != SS_BUSY))
    else $error("parse state and final status disagree");

  // A start request always reports in progress
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_advance && (s1_kind_q == KIND_START)) |=> (out_o.status == SS_BUSY))
    else $error("start request did not clear status");

  // Head end tag only with a complete head
  a_headend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_o.token_class == TK_HEADEND)) |-> (out_o.status == SS_COMPLETE))
    else $error("head end without complete status");
`endif

endmodule

// ===== rtl/hrht_classify.sv =====
module hrht_classify import hrht_pkg::*; (
  input  hrht_state_t  state_i,
  input  logic [1:0]   kind_i,
  input  logic [7:0]   byte_i,
  output hrht_state_t  state_o,
  output hrht_result_t result_o
);

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
  endfunction

  logic        in_req_line;
  logic [7:0]  c;
  hrht_state_t st;
  token_e      tk;
  logic [7:0]  ch;

  assign in_req_line = (state_i.parse_state <= ST_RL_ERROR);

  // Request-line bytes are lowercased before classification
  always_comb begin
    c = byte_i;
    if (in_req_line && is_upper(byte_i)) begin
      c = byte_i | CH_CASE_BIT;
    end
  end

  // Next state and token for this beat
  always_comb begin
    st = state_i;
    tk = TK_SKIP;
    ch = 8'd0;
    unique case (kind_i)
      KIND_START: begin
        st.parse_state   = ST_RL_START;
        st.value_started = 1'b0;
        st.final_status  = SS_BUSY;
      end
      KIND_EOS: begin
        if (state_i.parse_state <= ST_RL_ERROR) begin
          st.parse_state  = ST_DONE;
          st.final_status = SS_TRUNCATED;
        end else if (state_i.parse_state <= ST_HD_ERROR) begin
          st.parse_state  = ST_DONE;
          st.final_status = SS_COMPLETE;
        end
      end
      KIND_DATA: begin
        ch = c;
        unique case (state_i.parse_state)
          ST_RL_START: begin
            if (is_lower(c)) begin
              tk = TK_METHOD;
              st.parse_state = ST_RL_METHOD;
            end else if (c != CH_SPACE) begin
              st.parse_state = ST_RL_ERROR;
            end
          end
          ST_RL_METHOD: begin
            if (is_lower(c)) tk = TK_METHOD;
            else if (c == CH_SPACE) st.parse_state = ST_RL_URL;
          end
          ST_RL_URL: begin
            if (c != CH_SPACE) tk = TK_URL;
            else st.parse_state = ST_RL_VERSION;
          end
          ST_RL_VERSION: begin
            if (c != CH_CR) tk = TK_VERSION;
            else st.parse_state = ST_RL_END;
          end
          ST_RL_END: begin
            if (c == CH_LF) begin
              tk = TK_LINEEND;
              st.parse_state = ST_HD_START;
            end else begin
              st.parse_state  = ST_DONE;
              st.final_status = SS_BAD;
            end
          end
          ST_RL_ERROR, ST_HD_ERROR: begin
            st.parse_state  = ST_DONE;
            st.final_status = SS_BAD;
          end
          ST_HD_START: begin
            if (is_lower(c) || is_upper(c)) begin
              tk = TK_KEY;
              st.parse_state = ST_HD_KEY;
            end else begin
              st.parse_state = ST_HD_ERROR;
            end
          end
          ST_HD_KEY: begin
            if (c != CH_COLON) begin
              tk = TK_KEY;
            end else begin
              st.value_started = 1'b0;
              st.parse_state   = ST_HD_VALUE;
            end
          end
          ST_HD_VALUE: begin
            // leading spaces of a value are dropped
            if (c == CH_CR) begin
              st.parse_state = ST_HD_NEXT;
            end else if (state_i.value_started || (c != CH_SPACE)) begin
              tk = TK_VALUE;
              st.value_started = 1'b1;
            end
          end
          ST_HD_NEXT: begin
            if (c == CH_LF) begin
              tk = TK_LINEEND;
              st.parse_state = ST_HD_LINEEND;
            end else begin
              st.parse_state = ST_HD_ERROR;
            end
          end
          ST_HD_LINEEND: begin
            if (is_lower(c) || is_upper(c)) begin
              tk = TK_KEY;
              st.parse_state = ST_HD_KEY;
            end else if (c == CH_CR) begin
              st.parse_state = ST_HD_END;
            end else begin
              st.parse_state = ST_HD_ERROR;
            end
          end
          ST_HD_END: begin
            st.parse_state = ST_DONE;
            if (c == CH_LF) begin
              tk = TK_HEADEND;
              st.final_status = SS_COMPLETE;
            end else begin
              st.final_status = SS_BAD;
            end
          end
          default: begin
            // finished: byte passes with no tag
          end
        endcase
      end
      default: begin
        // unused kind: no change
      end
    endcase
  end

  assign state_o              = st;
  assign result_o.char_out    = ch;
  assign result_o.token_class = tk;
  assign result_o.status      = st.final_status;

endmodule
